// ===== rtl/tdpf_pkg.sv =====
// Package for the track duplicate pair finder: ring depth, widths, payload
// structs and the sequencer state type. No dependencies.
package tdpf_pkg;

  // Number of stored earlier reports in the ring.
  localparam int Depth       = 32;
  localparam int SlotW       = $clog2(Depth);
  localparam int FillW       = $clog2(Depth + 1);
  localparam int MaxResults  = 31;
  localparam int ResCntW     = $clog2(MaxResults + 1);
  localparam int MatchSlotW  = 5;
  localparam int TimeW       = 40;
  localparam logic [15:0] WindowReset = 16'd4700;

  typedef enum logic [0:0] {
    KIND_ADDRESS = 1'b0,
    KIND_BOARD   = 1'b1
  } match_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STORE
  } state_e;

  // One input report; also the layout of one ring entry.
  typedef struct packed {
    logic [TimeW-1:0] track_time_ms;
    logic [15:0]      track_id;
    logic             is_mode_s;
    logic [23:0]      aircraft_address;
    logic [11:0]      board_number;
  } trk_in_t;

  // One duplicate result.
  typedef struct packed {
    logic [MatchSlotW-1:0] match_slot;
    logic [15:0]           match_track_id;
    logic                  match_kind;
    logic [31:0]           duplicates_total;
    logic                  last_match;
  } trk_res_t;

endpackage

// ===== rtl/track_duplicate_pair_finder_unit.sv =====
// Top level of the track duplicate pair finder: report ring memory, scan
// sequencer and shared compare unit. Depends on tdpf_pkg.
//
// Usage: a report transaction is accepted at a rising edge where start is
// high and busy is low; item_i carries the report. The block then compares
// the new report against every stored earlier report, oldest first, one
// stored report per cycle through a single compare unit fed by a ring
// memory with a registered read port. Each duplicate found produces one
// result transaction on result_o, marked by result_valid_o for exactly one
// cycle; the receiver cannot stall, so results are simply presented.
// Because the last result of a report is only known at the end of the scan,
// each result is held in a pending register until the next duplicate or the
// end of the scan, and the final one carries last_match. At most 31 results
// are produced per report; later duplicates only advance duplicates_total.
// After the accepting edge, busy stays high while the block issues one memory
// read per stored report, then runs the last compare and writes the new
// report into the ring. The window register is written through cfg_we_i and
// cfg_wdata_i; the user must do so only while idle, as the block itself does
// not enforce this.
// Reset empties the ring (fill count and write slot to zero, no clearing pass
// since only written slots are ever read), clears the duplicate count and
// sets the window to 4700 ms.
module track_duplicate_pair_finder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tdpf_pkg::trk_in_t item_i,
  output logic              result_valid_o,
  output tdpf_pkg::trk_res_t result_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);

  tdpf_pkg::state_e state_q, state_d;
  tdpf_pkg::trk_in_t in_q, in_d;
  logic [15:0] window_q, window_d;
  logic [tdpf_pkg::SlotW-1:0] wr_slot_q, wr_slot_d;
  logic [tdpf_pkg::FillW-1:0] fill_q, fill_d;
  logic [31:0] dup_q, dup_d;
  logic [tdpf_pkg::SlotW-1:0] scan_slot_q, scan_slot_d;
  logic [tdpf_pkg::FillW-1:0] issue_q, issue_d;
  logic rd_v_q, rd_v_d;
  logic [tdpf_pkg::ResCntW-1:0] n_q, n_d;
  logic pend_v_q, pend_v_d;
  tdpf_pkg::trk_res_t pend_q, pend_d;
  tdpf_pkg::trk_res_t res_q, res_d;
  logic res_v_q, res_v_d;

  // Ring memory with a registered read port.
  tdpf_pkg::trk_in_t mem_q [tdpf_pkg::Depth];
  tdpf_pkg::trk_in_t mem_rd_q;
  logic [tdpf_pkg::SlotW-1:0] cmp_slot_q;

  logic rd_en;
  logic ring_full;
  logic [tdpf_pkg::SlotW-1:0] scan_slot_nxt;
  logic [tdpf_pkg::SlotW-1:0] wr_slot_nxt;

  // Compare unit signals.
  logic [tdpf_pkg::TimeW:0] diff;
  logic gap_ok;
  logic id_ne;
  logic addr_hit;
  logic board_hit;
  logic hit;
  logic [31:0] dup_inc;
  logic [tdpf_pkg::SlotW+tdpf_pkg::MatchSlotW-1:0] slot_wide;

  assign rd_en     = (state_q == tdpf_pkg::ST_SCAN) && (issue_q < fill_q);
  assign ring_full = (fill_q == tdpf_pkg::FillW'(tdpf_pkg::Depth));

  assign scan_slot_nxt = (scan_slot_q == tdpf_pkg::SlotW'(tdpf_pkg::Depth - 1)) ?
                         '0 : scan_slot_q + 1'b1;
  assign wr_slot_nxt   = (wr_slot_q == tdpf_pkg::SlotW'(tdpf_pkg::Depth - 1)) ?
                         '0 : wr_slot_q + 1'b1;

  // The stored report must be strictly earlier and by less than the window.
  assign diff   = {1'b0, in_q.track_time_ms} - {1'b0, mem_rd_q.track_time_ms};
  assign gap_ok = !diff[tdpf_pkg::TimeW] &&
                  (diff[tdpf_pkg::TimeW-1:0] != '0) &&
                  (diff[tdpf_pkg::TimeW-1:0] < {24'd0, window_q});
  assign id_ne  = (in_q.track_id != mem_rd_q.track_id);
  assign addr_hit  = in_q.is_mode_s && mem_rd_q.is_mode_s &&
                     (in_q.aircraft_address == mem_rd_q.aircraft_address);
  assign board_hit = !in_q.is_mode_s && !mem_rd_q.is_mode_s &&
                     (in_q.board_number == mem_rd_q.board_number);
  assign hit       = rd_v_q && id_ne && gap_ok && (addr_hit || board_hit);
  assign dup_inc   = (dup_q == 32'hFFFF_FFFF) ? dup_q : dup_q + 32'd1;
  assign slot_wide = {{tdpf_pkg::MatchSlotW{1'b0}}, cmp_slot_q};

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    window_d    = window_q;
    wr_slot_d   = wr_slot_q;
    fill_d      = fill_q;
    dup_d       = dup_q;
    scan_slot_d = scan_slot_q;
    issue_d     = issue_q;
    rd_v_d      = 1'b0;
    n_d         = n_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    res_d       = res_q;
    res_v_d     = 1'b0;

    if (cfg_we_i) begin
      window_d = cfg_wdata_i;
    end

    case (state_q)
      tdpf_pkg::ST_IDLE: begin
        if (start) begin
          in_d        = item_i;
          issue_d     = '0;
          n_d         = '0;
          pend_v_d    = 1'b0;
          scan_slot_d = ring_full ? wr_slot_q : '0;
          state_d     = tdpf_pkg::ST_SCAN;
        end
      end
      tdpf_pkg::ST_SCAN: begin
        rd_v_d = rd_en;
        if (rd_en) begin
          scan_slot_d = scan_slot_nxt;
          issue_d     = issue_q + 1'b1;
        end
        if (hit) begin
          dup_d = dup_inc;
          if (n_q < tdpf_pkg::ResCntW'(tdpf_pkg::MaxResults)) begin
            n_d                     = n_q + 1'b1;
            pend_v_d                = 1'b1;
            pend_d.match_slot       = slot_wide[tdpf_pkg::MatchSlotW-1:0];
            pend_d.match_track_id   = mem_rd_q.track_id;
            pend_d.match_kind       = addr_hit ? tdpf_pkg::KIND_ADDRESS :
                                                 tdpf_pkg::KIND_BOARD;
            pend_d.duplicates_total = dup_inc;
            pend_d.last_match       = 1'b0;
            // A newer duplicate proves the held one was not the last.
            if (pend_v_q) begin
              res_d   = pend_q;
              res_v_d = 1'b1;
            end
          end
        end
        // Once every read is issued, the last compare runs in this cycle and
        // the store follows directly.
        if (!rd_en) begin
          state_d = tdpf_pkg::ST_STORE;
        end
      end
      tdpf_pkg::ST_STORE: begin
        if (pend_v_q) begin
          res_d            = pend_q;
          res_d.last_match = 1'b1;
          res_v_d          = 1'b1;
          pend_v_d         = 1'b0;
        end
        wr_slot_d = wr_slot_nxt;
        if (!ring_full) begin
          fill_d = fill_q + 1'b1;
        end
        state_d = tdpf_pkg::ST_IDLE;
      end
      default: begin
        state_d = tdpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tdpf_pkg::ST_IDLE;
      window_q  <= tdpf_pkg::WindowReset;
      wr_slot_q <= '0;
      fill_q    <= '0;
      dup_q     <= '0;
      issue_q   <= '0;
      rd_v_q    <= 1'b0;
      n_q       <= '0;
      pend_v_q  <= 1'b0;
      res_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      window_q  <= window_d;
      wr_slot_q <= wr_slot_d;
      fill_q    <= fill_d;
      dup_q     <= dup_d;
      issue_q   <= issue_d;
      rd_v_q    <= rd_v_d;
      n_q       <= n_d;
      pend_v_q  <= pend_v_d;
      res_v_q   <= res_v_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    scan_slot_q <= scan_slot_d;
    pend_q      <= pend_d;
    res_q       <= res_d;
  end

  // Ring memory: one write port used while storing, one registered read port.
  always_ff @(posedge clk_i) begin
    if (state_q == tdpf_pkg::ST_STORE) begin
      mem_q[wr_slot_q] <= in_q;
    end
    if (rd_en) begin
      mem_rd_q   <= mem_q[scan_slot_q];
      cmp_slot_q <= scan_slot_q;
    end
  end

  assign busy           = (state_q != tdpf_pkg::ST_IDLE);
  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // Never more reads issued than there are stored reports.
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q <= fill_q)
    else $error("scan issued more reads than stored reports");

  // A held result never survives past the store step.
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdpf_pkg::ST_IDLE) |-> !pend_v_q)
    else $error("pending result left over in idle");

  // Compare data is only valid during the scan.
  a_rd_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> (state_q == tdpf_pkg::ST_SCAN))
    else $error("compare data valid outside the scan");

  // The final result of a report is followed by an idle result slot.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_match) |=> !result_valid_o)
    else $error("result directly after a final result");

  // An accepted report makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted report did not start a scan");

endmodule
